/* rtl/iprl_pkg.sv */
// shared types and constants for the ip range location lookup block
// no dependencies; imported by every module of the block except iprl_ram
`timescale 1ns / 1ps
`default_nettype none

package iprl_pkg;

    // default table geometry
    localparam int IPRL_TABLE_DEPTH = 4096;
    localparam int IPRL_CODE_BITS   = 16;

    // fixed field widths of the ports
    localparam int ADDR_W   = 32;
    localparam int CODE_W   = 16;
    localparam int STATUS_W = 3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_BAD_RANGE  = 3'd2,
        ST_NOT_RISING = 3'd3,
        ST_FULL       = 3'd4
    } iprl_status_t;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // lookup context handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } iprl_probe_t;

    // finished result beat
    typedef struct packed {
        logic              valid;
        iprl_status_t      status;
        logic [CODE_W-1:0] code;
    } iprl_result_t;

endpackage

`default_nettype wire

/* rtl/iprl_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iprl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/iprl_cell.sv */
// one search cell: decides one bit of the lower-bound index
// holds the end addresses probed at its level; uses iprl_pkg and iprl_ram
`timescale 1ns / 1ps
`default_nettype none

module iprl_cell
    import iprl_pkg::*;
#(
    parameter int IDX_W = 12,
    parameter int LEVEL = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W:0]    count,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire logic [ADDR_W-1:0] wr_end,
    input  wire iprl_probe_t       probe_in,
    input  wire logic [IDX_W-1:0]  pos_in,
    output iprl_probe_t            probe_out,
    output logic      [IDX_W-1:0]  pos_out
);

    // this level holds every entry whose index ends in a zero and LEVEL ones
    localparam int RAW_DEPTH  = (1 << IDX_W) >> (LEVEL + 1);
    localparam int CELL_DEPTH = (RAW_DEPTH < 2) ? 2 : RAW_DEPTH;
    localparam int AW         = $clog2(CELL_DEPTH);
    localparam logic [IDX_W-1:0] LOW_MASK = IDX_W'((64'd1 << (LEVEL + 1)) - 64'd1);
    localparam logic [IDX_W-1:0] LOW_PAT  = IDX_W'((64'd1 << LEVEL) - 64'd1);
    localparam logic [IDX_W-1:0] STEP     = IDX_W'(64'd1 << LEVEL);

    logic              valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [ADDR_W-1:0] probe_end;
    logic              owns_entry;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [IDX_W:0]    reach;
    logic              take;

    // a new entry lands here when its index matches this level's pattern
    assign owns_entry = ((wr_idx & LOW_MASK) == LOW_PAT);
    assign wr_addr    = AW'(wr_idx >> (LEVEL + 1));
    assign rd_addr    = AW'(pos_in >> (LEVEL + 1));

    iprl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CELL_DEPTH)
    ) u_end_ram (
        .clk     (clk),
        .wr_en   (wr_en && owns_entry),
        .wr_addr (wr_addr),
        .wr_data (wr_end),
        .rd_addr (rd_addr),
        .rd_data (probe_end)
    );

    // context travels alongside the ram read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= probe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= probe_in.addr;
        pos_reg  <= pos_in;
    end

    // step over the probed entry when it exists and ends below the address
    assign reach = {1'b0, pos_reg} + {1'b0, STEP};
    assign take  = (reach <= count) && (probe_end < addr_reg);

    assign pos_out         = take ? (pos_reg | STEP) : pos_reg;
    assign probe_out.valid = valid_reg;
    assign probe_out.addr  = addr_reg;

endmodule

`default_nettype wire

/* rtl/iprl_match.sv */
// final stage: reads start and code of the located entry and builds the result
// uses iprl_pkg and iprl_ram
`timescale 1ns / 1ps
`default_nettype none

module iprl_match
    import iprl_pkg::*;
#(
    parameter int IDX_W     = 12,
    parameter int CODE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IDX_W:0]       count,
    input  wire logic [ADDR_W-1:0]    last_end,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  wire logic [ADDR_W-1:0]    wr_start,
    input  wire logic [CODE_BITS-1:0] wr_code,
    input  wire iprl_probe_t          probe_in,
    input  wire logic [IDX_W-1:0]     pos_in,
    output iprl_result_t              result
);

    localparam int ENTRY_W = ADDR_W + CODE_BITS;
    localparam int DEPTH   = 1 << IDX_W;

    logic                 valid_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [ENTRY_W-1:0]   entry;
    logic [ADDR_W-1:0]    entry_start;
    logic [CODE_BITS-1:0] entry_code;
    logic                 hit;

    iprl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data ({wr_start, wr_code}),
        .rd_addr (pos_in),
        .rd_data (entry)
    );

    assign entry_start = entry[ENTRY_W-1:CODE_BITS];
    assign entry_code  = entry[CODE_BITS-1:0];

    // context alongside the entry read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= probe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= probe_in.addr;
        pos_reg  <= pos_in;
    end

    // hit when the located entry exists and starts at or below the address;
    // an address above the newest end misses even when the table is full
    assign hit = ({1'b0, pos_reg} < count) && (entry_start <= addr_reg)
                 && (addr_reg <= last_end);

    assign result.valid  = valid_reg;
    assign result.status = hit ? ST_OK : ST_NOT_FOUND;
    assign result.code   = hit ? CODE_W'(entry_code) : '0;

endmodule

`default_nettype wire

/* rtl/ip_range_location_lookup_core.sv */
// an insert beat's result is registered at the accepting edge, into the output register or the spare slot;
// a lookup's result passes the chain of search cells, each registered, then the registered match stage;
// a new request is not taken while a lookup is in flight; the chain holds one search cell and one
// end-address ram per index bit; one insert per cycle while in_stall stays low
// reset: clears the entry count and all control state; table rams are not cleared
`timescale 1ns / 1ps
`default_nettype none

module ip_range_location_lookup_core
    import iprl_pkg::*;
#(
    parameter int TABLE_DEPTH = IPRL_TABLE_DEPTH,
    parameter int CODE_BITS   = IPRL_CODE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [ADDR_W-1:0]   lookup_address,
    input  wire logic [ADDR_W-1:0]   range_start,
    input  wire logic [ADDR_W-1:0]   range_end,
    input  wire logic [CODE_W-1:0]   location_code,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [STATUS_W-1:0] status,
    output logic      [CODE_W-1:0]   found_code
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W:0] DEPTH_CNT = (IDX_W + 1)'(TABLE_DEPTH);

    logic [IDX_W:0]       count_reg;
    logic [ADDR_W-1:0]    last_end_reg;
    logic                 busy_reg;
    logic                 accept;
    logic                 ins_ok;
    iprl_status_t         ins_status;
    logic [CODE_BITS-1:0] ins_code;
    iprl_probe_t          probe [IDX_W+1];
    logic [IDX_W-1:0]     pos   [IDX_W+1];
    iprl_result_t         look_res;
    iprl_result_t         push;
    logic                 out_valid_reg;
    iprl_status_t         out_status_reg;
    logic [CODE_W-1:0]    out_code_reg;
    logic                 spare_valid_reg;
    iprl_status_t         spare_status_reg;
    logic [CODE_W-1:0]    spare_code_reg;
    logic                 pop;

    // one lookup in flight; the spare slot must be free so its result has room
    assign in_stall = busy_reg || spare_valid_reg;
    assign accept   = in_valid && !in_stall;

    // insert checks in priority order
    always_comb
    begin
        ins_ok = 1'b0;
        if (range_start > range_end)
        begin
            ins_status = ST_BAD_RANGE;
        end
        else if ((count_reg != '0) && (last_end_reg >= range_end))
        begin
            ins_status = ST_NOT_RISING;
        end
        else if (count_reg >= DEPTH_CNT)
        begin
            ins_status = ST_FULL;
        end
        else
        begin
            ins_status = ST_OK;
            ins_ok     = 1'b1;
        end
    end

    assign ins_code = CODE_BITS'(location_code);

    // entry count, newest end and lookup busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (accept && (op == OP_INSERT) && ins_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept && (op == OP_LOOKUP))
            begin
                busy_reg <= 1'b1;
            end
            else if (look_res.valid)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_INSERT) && ins_ok)
        begin
            last_end_reg <= range_end;
        end
    end

    // head of the search chain
    assign probe[0].valid = accept && (op == OP_LOOKUP);
    assign probe[0].addr  = lookup_address;
    assign pos[0]         = '0;

    // search cells, most significant index bit first
    for (genvar i = 0; i < IDX_W; i++)
    begin : g_cell
        iprl_cell #(
            .IDX_W (IDX_W),
            .LEVEL (IDX_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count_reg),
            .wr_en     (accept && (op == OP_INSERT) && ins_ok),
            .wr_idx    (count_reg[IDX_W-1:0]),
            .wr_end    (range_end),
            .probe_in  (probe[i]),
            .pos_in    (pos[i]),
            .probe_out (probe[i+1]),
            .pos_out   (pos[i+1])
        );
    end

    iprl_match #(
        .IDX_W     (IDX_W),
        .CODE_BITS (CODE_BITS)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .count    (count_reg),
        .last_end (last_end_reg),
        .wr_en    (accept && (op == OP_INSERT) && ins_ok),
        .wr_idx   (count_reg[IDX_W-1:0]),
        .wr_start (range_start),
        .wr_code  (ins_code),
        .probe_in (probe[IDX_W]),
        .pos_in   (pos[IDX_W]),
        .result   (look_res)
    );

    // result entering the output buffer: insert outcome or finished lookup
    always_comb
    begin
        if (look_res.valid)
        begin
            push = look_res;
        end
        else
        begin
            push.valid  = accept && (op == OP_INSERT);
            push.status = ins_status;
            push.code   = '0;
        end
    end

    // output register with one spare slot behind it
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (spare_valid_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    spare_valid_reg <= push.valid;
                end
                else
                begin
                    out_valid_reg <= push.valid;
                end
            end
            else if (push.valid)
            begin
                spare_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (spare_valid_reg)
            begin
                out_status_reg   <= spare_status_reg;
                out_code_reg     <= spare_code_reg;
                spare_status_reg <= push.status;
                spare_code_reg   <= push.code;
            end
            else
            begin
                out_status_reg <= push.status;
                out_code_reg   <= push.code;
            end
        end
        else if (push.valid)
        begin
            spare_status_reg <= push.status;
            spare_code_reg   <= push.code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_code = out_code_reg;

    // a lookup result only comes out of the chain while a lookup is in flight
    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        look_res.valid |-> busy_reg)
        else $error("lookup result without a lookup in flight");

    // the spare slot is only used behind a held output beat
    a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> out_valid_reg)
        else $error("spare slot filled while output register empty");

    // the table never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    // an accepted lookup is tracked as in flight: the busy flag is set and its result has not yet landed
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_LOOKUP)) |=> (busy_reg && !look_res.valid))
        else $error("lookup not tracked as in flight");

endmodule

`default_nettype wire

/* test/tb.sv */
// self-checking testbench for ip_range_location_lookup_core: range inserts and address lookups
// driven through valid/stall channels, results checked against an in-bench table predictor
// depends on rtl/iprl_pkg.sv and rtl/ip_range_location_lookup_core.sv
`timescale 1ns / 1ps

module tb;
    import iprl_pkg::*;

    localparam int DEPTH        = IPRL_TABLE_DEPTH;
    localparam int SLOT_BITS    = ADDR_W - $clog2(DEPTH);
    localparam int SEARCH_LAT   = $clog2(DEPTH) + 2;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << IPRL_CODE_BITS) - 1);

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [CODE_W-1:0] code;
    } range_req_t;

    typedef struct {
        iprl_status_t      status;
        logic [CODE_W-1:0] code;
    } lookup_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_LOOKUP;
    logic [ADDR_W-1:0] lookup_address = '0;
    logic [ADDR_W-1:0] range_start = '0;
    logic [ADDR_W-1:0] range_end = '0;
    logic [CODE_W-1:0] location_code = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0] found_code;

    // stimulus bookkeeping: ranges that the generated inserts will store
    logic [ADDR_W-1:0] plan_start [DEPTH];
    logic [ADDR_W-1:0] plan_end [DEPTH];
    int plan_count = 0;

    // predicted table contents
    logic [ADDR_W-1:0] tbl_start [DEPTH];
    logic [ADDR_W-1:0] tbl_end [DEPTH];
    logic [CODE_W-1:0] tbl_code [DEPTH];
    int tbl_count = 0;

    range_req_t queued_requests [$];
    lookup_answer_t awaited_answers [$];

    int mismatch_count = 0;
    int answer_count = 0;
    int cycle_count = 0;
    int lookups_hit = 0;
    int lookups_missed = 0;
    int inserts_stored = 0;
    int inserts_refused = 0;

    logic in_taken = 1'b0;
    int gap_left = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_phase_left = 0;

    ip_range_location_lookup_core #(
        .TABLE_DEPTH(DEPTH),
        .CODE_BITS  (IPRL_CODE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .lookup_address(lookup_address),
        .range_start   (range_start),
        .range_end     (range_end),
        .location_code (location_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_code    (found_code)
    );

    // clock and a single reset at the start
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // predictor: applies one request to the table and gives its answer
    function automatic lookup_answer_t apply_table_op(input range_req_t req);
        lookup_answer_t ans;
        int lo;
        int hi;
        int mid;
        ans.status = ST_OK;
        ans.code   = '0;
        if (req.op == OP_INSERT)
        begin
            if (req.first > req.last)
                ans.status = ST_BAD_RANGE;
            else if (tbl_count > 0 && tbl_end[tbl_count-1] >= req.last)
                ans.status = ST_NOT_RISING;
            else if (tbl_count >= DEPTH)
                ans.status = ST_FULL;
            else
            begin
                tbl_start[tbl_count] = req.first;
                tbl_end[tbl_count]   = req.last;
                tbl_code[tbl_count]  = req.code & CODE_MASK;
                tbl_count++;
            end
        end
        else
        begin
            // lower bound on the end address
            lo = 0;
            hi = tbl_count;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tbl_end[mid] < req.addr)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < tbl_count && tbl_start[lo] <= req.addr)
                ans.code = tbl_code[lo];
            else
                ans.status = ST_NOT_FOUND;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // stimulus helpers
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return CODE_W'($urandom);
    endfunction

    task automatic push_lookup(input logic [ADDR_W-1:0] addr);
        range_req_t req;
        req.op    = OP_LOOKUP;
        req.addr  = addr;
        req.first = $urandom;
        req.last  = $urandom;
        req.code  = CODE_W'($urandom);
        queued_requests.push_back(req);
    endtask

    task automatic push_insert(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last,
                               input logic [CODE_W-1:0] code);
        range_req_t req;
        req.op    = OP_INSERT;
        req.addr  = $urandom;
        req.first = first;
        req.last  = last;
        req.code  = code;
        queued_requests.push_back(req);
    endtask

    task automatic plan_entry(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last,
                              input logic [CODE_W-1:0] code);
        plan_start[plan_count] = first;
        plan_end[plan_count]   = last;
        plan_count++;
        push_insert(first, last, code);
    endtask

    // insert that is sure to be stored: each entry gets its own slice of the address space
    task automatic gen_good_insert();
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [63:0] top;
        int r;
        lo  = (plan_count == 0) ? '0 : plan_end[plan_count-1] + 1;
        top = ((64'(plan_count) + 1) << SLOT_BITS) - 1;
        hi  = (top >= 64'hFFFF_FFFE) ? 32'hFFFF_FFFE : top[ADDR_W-1:0];
        r = $urandom_range(3, 0);
        first = (r == 0) ? lo : lo + $urandom_range((hi - lo) / 2, 0);
        r = $urandom_range(3, 0);
        if (plan_count == DEPTH - 1)
            last = 32'hFFFF_FFFE;
        else if (r == 0)
            last = first;
        else if (r == 1)
            last = first + $urandom_range((hi - first) < 255 ? hi - first : 255, 0);
        else
            last = first + $urandom_range(hi - first, 0);
        plan_entry(first, last, pick_code());
    endtask

    // lookup aimed at a stored range, a gap before it, the space above all ends, or a random address
    task automatic gen_good_lookup();
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] lo_gap;
        logic [ADDR_W-1:0] top_end;
        int idx;
        int kind;
        if (plan_count == 0)
        begin
            push_lookup($urandom);
            return;
        end
        idx     = $urandom_range(plan_count - 1, 0);
        kind    = $urandom_range(9, 0);
        top_end = plan_end[plan_count-1];
        lo_gap  = (idx == 0) ? '0 : plan_end[idx-1] + 1;
        if (kind == 0)
            addr = plan_start[idx];
        else if (kind == 1)
            addr = plan_end[idx];
        else if (kind <= 5)
            addr = plan_start[idx] + $urandom_range(plan_end[idx] - plan_start[idx], 0);
        else if (kind <= 7 && plan_start[idx] > lo_gap)
            addr = lo_gap + $urandom_range(plan_start[idx] - lo_gap - 1, 0);
        else if (kind == 8 && top_end != 32'hFFFF_FFFF)
            addr = top_end + 1 + $urandom_range(32'hFFFF_FFFF - top_end - 1, 0);
        else
            addr = $urandom;
        push_lookup(addr);
    endtask

    // inserts built to be refused, and blind lookups
    task automatic gen_noise();
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        int kind;
        kind = $urandom_range(2, 0);
        if (kind == 1 && plan_count > 0)
        begin
            last  = ($urandom_range(2, 0) == 0) ? plan_end[plan_count-1]
                                                : $urandom_range(plan_end[plan_count-1], 0);
            first = $urandom_range(last, 0);
            push_insert(first, last, pick_code());
        end
        else if (kind == 2)
            push_lookup($urandom);
        else
        begin
            last = $urandom;
            if (last == 32'hFFFF_FFFF)
                last = last - 1;
            first = last + 1 + $urandom_range(32'hFFFF_FFFF - last - 1, 0);
            push_insert(first, last, pick_code());
        end
    endtask

    // build the whole request list
    initial
    begin
        int r;
        // empty table, rejections and small hand-made ranges
        push_lookup(32'h0000_0000);
        push_lookup(32'hFFFF_FFFF);
        push_insert(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
        plan_entry(32'h0000_0000, 32'h0000_0000, 16'h0000);
        push_insert(32'h0000_0000, 32'h0000_0000, 16'h1234);
        push_insert(32'hFFFF_FFFF, 32'h0000_0000, 16'h0001);
        push_lookup(32'h0000_0000);
        push_lookup(32'h0000_0001);
        plan_entry(32'h0000_0010, 32'h0000_001F, 16'hFFFF);
        plan_entry(32'h0000_0020, 32'h0000_002F, 16'hA5A5);
        push_lookup(32'h0000_0008);
        push_lookup(32'h0000_0010);
        push_lookup(32'h0000_001F);
        push_lookup(32'h0000_0020);
        push_lookup(32'h0000_0030);
        plan_entry(32'h0000_0030, 32'h0000_0030, 16'h5A5A);
        push_lookup(32'h0000_0030);
        push_lookup(32'hFFFF_FFFF);
        push_insert(32'h0000_0000, 32'h0000_002F, 16'h00FF);
        push_insert(32'h0000_0031, 32'h0000_0030, 16'hFF00);

        // random mix, mostly well-formed
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 45 && plan_count < DEPTH)
                gen_good_insert();
            else if (r < 80)
                gen_good_lookup();
            else
                gen_noise();
        end

        // top of the address space: one range at the very top, then refusals and probes
        push_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        push_insert(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000);
        push_insert(32'hFFFF_FFFF, 32'hFFFF_FFFE, 16'h1111);
        push_insert(32'h0000_0000, 32'hFFFF_FFFE, 16'h2222);
        push_lookup(32'hFFFF_FFFE);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'h0000_0000);
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(1, 0) == 0)
                gen_good_lookup();
            else
                gen_noise();
        end
    end

    // request driver: bursts of random length with random gaps
    always @(negedge clk)
    begin
        range_req_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0 || queued_requests.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                nxt = queued_requests.pop_front();
                in_valid       <= 1'b1;
                op             <= nxt.op;
                lookup_address <= nxt.addr;
                range_start    <= nxt.first;
                range_end      <= nxt.last;
                location_code  <= nxt.code;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(24, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // result stall: phases of no stall, random stall and long periodic stall
    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       <= $urandom_range(2, 0);
            stall_phase_left <= $urandom_range(200, 40);
            out_stall        <= 1'b0;
        end
        else
        begin
            stall_phase_left <= stall_phase_left - 1;
            if (stall_mode == 1)
                out_stall <= ($urandom_range(2, 0) == 0);
            else if (stall_mode == 2)
                out_stall <= ((stall_phase_left % 32) > 20);
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: predict on each accepted request beat, check each accepted result beat
    always @(posedge clk)
    begin
        range_req_t req;
        lookup_answer_t ans;
        lookup_answer_t want;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                req.op    = op;
                req.addr  = lookup_address;
                req.first = range_start;
                req.last  = range_end;
                req.code  = location_code;
                ans = apply_table_op(req);
                awaited_answers.push_back(ans);
                if (req.op == OP_INSERT)
                begin
                    if (ans.status == ST_OK)
                        inserts_stored++;
                    else
                        inserts_refused++;
                end
                else if (ans.status == ST_OK)
                    lookups_hit++;
                else
                    lookups_missed++;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch($sformatf("result beat %0d with nothing awaited",
                                              answer_count));
                else
                begin
                    want = awaited_answers.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("beat %0d status exp %0d got %0d",
                                                  answer_count, want.status, status));
                    if (found_code !== want.code)
                        report_mismatch($sformatf("beat %0d found_code exp %h got %h",
                                                  answer_count, want.code, found_code));
                end
                answer_count++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results awaited", cycle_count,
                     awaited_answers.size());
            $display("ip_range_location_lookup_core regression: fail");
            $finish;
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        while (queued_requests.size() != 0 || in_valid || awaited_answers.size() != 0)
            @(negedge clk);
        repeat (2 * SEARCH_LAT) @(posedge clk);
        $display("lookups: %0d hits, %0d misses; inserts: %0d stored, %0d refused",
                 lookups_hit, lookups_missed, inserts_stored, inserts_refused);
        $display("table reached %0d of %0d entries, %0d results checked, %0d mismatches",
                 tbl_count, DEPTH, answer_count, mismatch_count);
        if (mismatch_count == 0)
            $display("ip_range_location_lookup_core regression: pass");
        else
            $display("ip_range_location_lookup_core regression: fail");
        $finish;
    end

endmodule
